@@ hw/rtl/mtg_pkg.sv @@
// Shared types, constants and word functions for the MT19937 generator.
`timescale 1ns / 1ps

package mtg_pkg;

	localparam int unsigned MT_LEN   = 624;
	localparam int unsigned MT_SHIFT = 397;
	localparam int unsigned IDX_W    = 10;

	localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(MT_LEN - 1);
	localparam logic [IDX_W-1:0] POS_EMPTY   = IDX_W'(MT_LEN);
	localparam logic [IDX_W-1:0] POS_PENDING = IDX_W'(MT_LEN + 1);

	localparam logic [31:0] MT_UPPER     = 32'h8000_0000;
	localparam logic [31:0] MT_LOWER     = 32'h7fff_ffff;
	localparam logic [31:0] MT_MATRIX    = 32'h9908_b0df;
	localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
	localparam logic [31:0] MT_TEMPER_B  = 32'h9d2c_5680;
	localparam logic [31:0] MT_TEMPER_C  = 32'hefc6_0000;
	localparam logic [31:0] SEED_RESET   = 32'd5489;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED0,
		ST_SEED_MUL,
		ST_SEED_ADD,
		ST_PRIME0,
		ST_PRIME1,
		ST_TWIST,
		ST_READ,
		ST_PUSH
	} mtg_state_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [31:0]      wdata;
		logic             re;
		logic [IDX_W-1:0] raddr_a;
		logic [IDX_W-1:0] raddr_b;
	} mtg_ram_req_t;

	typedef struct packed {
		logic             idle;
		logic             push;
		logic [IDX_W-1:0] word_pos;
	} mtg_status_t;

	function automatic logic [31:0] mix_pair(input logic [31:0] upper_src,
						 input logic [31:0] lower_src);
		logic [31:0] h;
		h = (upper_src & MT_UPPER) | (lower_src & MT_LOWER);
		return (h >> 1) ^ (h[0] ? MT_MATRIX : 32'h0);
	endfunction

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] e;
		e = w;
		e = e ^ (e >> 11);
		e = e ^ ((e << 7) & MT_TEMPER_B);
		e = e ^ ((e << 15) & MT_TEMPER_C);
		e = e ^ (e >> 18);
		return e;
	endfunction

endpackage

@@ hw/rtl/mt19937_generator.sv @@
// Top level of the MT19937 generator: state table, sequencer and output register.
`timescale 1ns / 1ps

// Each accepted transaction with request set returns one tempered 32-bit word of the
// standard MT19937 sequence; a transaction with request clear returns nothing. The
// 624-word state lives in a memory with one write port, so the twist pass writes one
// entry per cycle. A plain request goes through accept, table read and output load.
// Every 624th word first twists the table in place. The first request after reset or
// after a write of seed_value also fills the table from the seed, with a multiply step
// and an add step per entry, before that twist.
// The output register lets the next request be taken while a word waits on m_tready.
// Write seed_value only while the block is idle.

module mt19937_generator
	import mtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,          // [0] request, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,          // [31:0] random_word
	input  logic        seed_value_we,
	input  logic [31:0] seed_value_wdata
);

	mtg_ram_req_t ram_req;
	mtg_status_t  status;
	logic [31:0]  rd_a, rd_b;
	logic         slot_free;

	assign slot_free = !m_tvalid || m_tready;
	assign s_tready  = status.idle;

	mtg_ram u_ram (
		.clk  (clk),
		.req  (ram_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	mtg_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.request          (s_tdata[0]),
		.seed_value_we    (seed_value_we),
		.seed_value_wdata (seed_value_wdata),
		.slot_free        (slot_free),
		.rd_a             (rd_a),
		.rd_b             (rd_b),
		.ram_req          (ram_req),
		.status           (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (status.push) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.push) begin
			m_tdata <= temper(rd_a);
		end
	end

	// A word is loaded only when the output register is empty or draining.
	assert property (@(posedge clk) disable iff (!arst_n)
		status.push |-> (!m_tvalid || m_tready))
		else $error("output word overwritten before transfer");

	// Table writes and word delivery never overlap.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && status.push))
		else $error("table write during word delivery");

	// The position never leaves its legal range.
	assert property (@(posedge clk) disable iff (!arst_n)
		status.word_pos <= POS_PENDING)
		else $error("word position out of range");

	// A request transaction makes the block busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata[0]) |=> !s_tready)
		else $error("request accepted without starting work");

	// Writes stay inside the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (ram_req.waddr <= IDX_LAST))
		else $error("table write address out of range");

endmodule

@@ hw/rtl/mtg_ram.sv @@
// State table memory: one write port and two registered read ports.
`timescale 1ns / 1ps

module mtg_ram
	import mtg_pkg::*;
(
	input  logic         clk,
	input  mtg_ram_req_t req,
	output logic [31:0]  rd_a,
	output logic [31:0]  rd_b
);

	logic [31:0] mem [0:MT_LEN-1];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_a <= mem[req.raddr_a];
			rd_b <= mem[req.raddr_b];
		end
	end

endmodule

@@ hw/rtl/mtg_ctrl.sv @@
// Sequencer for seeding, in-place twisting and word reads of the state table.
`timescale 1ns / 1ps

module mtg_ctrl
	import mtg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         request,
	input  logic         seed_value_we,
	input  logic [31:0]  seed_value_wdata,
	input  logic         slot_free,
	input  logic [31:0]  rd_a,
	input  logic [31:0]  rd_b,
	output mtg_ram_req_t ram_req,
	output mtg_status_t  status
);

	mtg_state_t       state_q, state_d;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] rda_q, rdb_q;
	logic [31:0]      seed_q;
	logic [31:0]      prev_q;
	logic [31:0]      prod_s1;
	logic [31:0]      cur_q;
	logic [31:0]      seed_sum;
	logic [IDX_W-1:0] rda_inc, rdb_inc;

	assign seed_sum = prod_s1 + {{(32-IDX_W){1'b0}}, idx_q};
	assign rda_inc  = (rda_q == IDX_LAST) ? '0 : rda_q + 1'b1;
	assign rdb_inc  = (rdb_q == IDX_LAST) ? '0 : rdb_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		ram_req        = '0;
		status.idle    = 1'b0;
		status.push    = 1'b0;
		status.word_pos = pos_q;
		case (state_q)
			ST_IDLE: begin
				status.idle = 1'b1;
				if (s_tvalid && request) begin
					if (pos_q >= POS_PENDING) begin
						state_d = ST_SEED0;
					end else if (pos_q == POS_EMPTY) begin
						state_d = ST_PRIME0;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_SEED0: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = '0;
				ram_req.wdata = seed_q;
				state_d       = ST_SEED_MUL;
			end
			ST_SEED_MUL: begin
				state_d = ST_SEED_ADD;
			end
			ST_SEED_ADD: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_q;
				ram_req.wdata = seed_sum;
				state_d       = (idx_q == IDX_LAST) ? ST_PRIME0 : ST_SEED_MUL;
			end
			ST_PRIME0: begin
				ram_req.re      = 1'b1;
				ram_req.raddr_a = '0;
				ram_req.raddr_b = '0;
				state_d         = ST_PRIME1;
			end
			ST_PRIME1: begin
				ram_req.re      = 1'b1;
				ram_req.raddr_a = IDX_W'(1);
				ram_req.raddr_b = IDX_W'(MT_SHIFT);
				state_d         = ST_TWIST;
			end
			ST_TWIST: begin
				// The entry being written never matches an address read in the same cycle.
				ram_req.we      = 1'b1;
				ram_req.waddr   = idx_q;
				ram_req.wdata   = rd_b ^ mix_pair(cur_q, rd_a);
				ram_req.re      = 1'b1;
				ram_req.raddr_a = rda_q;
				ram_req.raddr_b = rdb_q;
				if (idx_q == IDX_LAST) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				ram_req.re      = 1'b1;
				ram_req.raddr_a = pos_q;
				ram_req.raddr_b = pos_q;
				state_d         = ST_PUSH;
			end
			ST_PUSH: begin
				if (slot_free) begin
					status.push = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_PENDING;
			seed_q <= SEED_RESET;
		end else if (seed_value_we) begin
			pos_q  <= POS_PENDING;
			seed_q <= seed_value_wdata;
		end else if (state_q == ST_TWIST && idx_q == IDX_LAST) begin
			pos_q <= '0;
		end else if (state_q == ST_READ) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SEED0: begin
				prev_q <= seed_q;
				idx_q  <= IDX_W'(1);
			end
			ST_SEED_MUL: begin
				prod_s1 <= 32'(MT_INIT_MULT * (prev_q ^ (prev_q >> 30)));
			end
			ST_SEED_ADD: begin
				prev_q <= seed_sum;
				idx_q  <= idx_q + 1'b1;
			end
			ST_PRIME1: begin
				cur_q <= rd_a;
				idx_q <= '0;
				rda_q <= IDX_W'(2);
				rdb_q <= IDX_W'(MT_SHIFT + 1);
			end
			ST_TWIST: begin
				cur_q <= rd_a;
				idx_q <= idx_q + 1'b1;
				rda_q <= rda_inc;
				rdb_q <= rdb_inc;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ sim/mt19937_generator_test.sv @@
// Self-checking testbench for the MT19937 generator with its own word predictor.
`timescale 1ns / 1ps

module mt19937_generator_test;

	localparam int unsigned TBL_LEN      = 624;
	localparam int unsigned TBL_SHIFT    = 397;
	localparam int unsigned POS_SEED_DUE = 625;
	localparam logic [31:0] HI_BIT       = 32'h8000_0000;
	localparam logic [31:0] LO_BITS      = 32'h7fff_ffff;
	localparam logic [31:0] TWIST_XOR    = 32'h9908_b0df;
	localparam logic [31:0] FILL_MULT    = 32'd1812433253;
	localparam logic [31:0] SHAPE_B      = 32'h9d2c_5680;
	localparam logic [31:0] SHAPE_C      = 32'hefc6_0000;
	localparam logic [31:0] BOOT_SEED    = 32'd5489;

	localparam int SETTLE_CYCLES = 2000;
	localparam int TAIL_CYCLES   = 50;
	localparam int STALL_LIMIT   = 20000;
	localparam int SHOWN_ERRORS  = 10;

	typedef enum logic [1:0] {
		ROW_REQ,
		ROW_IDLE,
		ROW_SEED
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] arg;
		logic        typed;
		logic [31:0] want;
	} plan_row_t;

	localparam int PLAN_ROWS = 23;

	// The first words of the sequence under the boot seed are well known and typed in.
	plan_row_t plan [PLAN_ROWS] = '{
		'{ROW_REQ,  32'd0,          1'b1, 32'd3499211612},
		'{ROW_REQ,  32'd0,          1'b1, 32'd581869302},
		'{ROW_REQ,  32'd0,          1'b1, 32'd3890346734},
		'{ROW_REQ,  32'd0,          1'b1, 32'd3586334585},
		'{ROW_REQ,  32'd0,          1'b1, 32'd545404204},
		'{ROW_IDLE, 32'd0,          1'b0, 32'd0},
		'{ROW_REQ,  32'd0,          1'b1, 32'd4161255391},
		'{ROW_IDLE, 32'd0,          1'b0, 32'd0},
		'{ROW_IDLE, 32'd0,          1'b0, 32'd0},
		'{ROW_REQ,  32'd0,          1'b1, 32'd3922919429},
		'{ROW_SEED, 32'h0000_0000,  1'b0, 32'd0},
		'{ROW_REQ,  32'd0,          1'b0, 32'd0},
		'{ROW_REQ,  32'd0,          1'b0, 32'd0},
		'{ROW_IDLE, 32'd0,          1'b0, 32'd0},
		'{ROW_REQ,  32'd0,          1'b0, 32'd0},
		'{ROW_SEED, 32'hffff_ffff,  1'b0, 32'd0},
		'{ROW_REQ,  32'd0,          1'b0, 32'd0},
		'{ROW_REQ,  32'd0,          1'b0, 32'd0},
		'{ROW_SEED, BOOT_SEED,      1'b0, 32'd0},
		'{ROW_REQ,  32'd0,          1'b1, 32'd3499211612},
		'{ROW_REQ,  32'd0,          1'b1, 32'd581869302},
		'{ROW_SEED, 32'h8000_0000,  1'b0, 32'd0},
		'{ROW_REQ,  32'd0,          1'b0, 32'd0}
	};

	logic        clk              = 1'b0;
	logic        arst_n           = 1'b0;
	logic        s_tvalid         = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata          = 8'h00;   // [0] request, [7:1] zero
	logic        m_tvalid;
	logic        m_tready         = 1'b0;
	logic [31:0] m_tdata;                    // [31:0] random_word
	logic        seed_value_we    = 1'b0;
	logic [31:0] seed_value_wdata = 32'h0;

	// Predictor copy of the generator state.
	logic [31:0] tbl [TBL_LEN];
	int unsigned tbl_pos;
	logic [31:0] tbl_seed;

	logic [31:0] pending_words [$];
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          idle_run      = 0;
	int          fail_count    = 0;
	int          words_checked = 0;
	int          seeds_used;
	int          twist_count;

	mt19937_generator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.seed_value_we    (seed_value_we),
		.seed_value_wdata (seed_value_wdata)
	);

	always #2 clk = ~clk;

	function automatic void fill_from_seed();
		logic [31:0] p;
		tbl[0] = tbl_seed;
		for (int i = 1; i < TBL_LEN; i++) begin
			p = tbl[i-1];
			tbl[i] = FILL_MULT * (p ^ (p >> 30)) + 32'(i);
		end
	endfunction

	function automatic void churn_table();
		logic [31:0] y;
		for (int i = 0; i < TBL_LEN; i++) begin
			y = (tbl[i] & HI_BIT) | (tbl[(i + 1) % TBL_LEN] & LO_BITS);
			tbl[i] = tbl[(i + TBL_SHIFT) % TBL_LEN] ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'h0);
		end
		twist_count++;
	endfunction

	function automatic logic [31:0] shape_word(input logic [31:0] raw);
		logic [31:0] e;
		e = raw;
		e = e ^ (e >> 11);
		e = e ^ ((e << 7) & SHAPE_B);
		e = e ^ ((e << 15) & SHAPE_C);
		e = e ^ (e >> 18);
		return e;
	endfunction

	function automatic logic [31:0] mt_next_word();
		logic [31:0] raw;
		if (tbl_pos > TBL_LEN)
			fill_from_seed();
		if (tbl_pos >= TBL_LEN) begin
			churn_table();
			tbl_pos = 0;
		end
		raw = tbl[tbl_pos];
		tbl_pos++;
		return shape_word(raw);
	endfunction

	function automatic void note_fail(input string what);
		fail_count++;
		if (fail_count <= SHOWN_ERRORS)
			$display("ERROR @%0t: %s", $realtime, what);
	endfunction

	// Offers one transaction, with random idle cycles ahead of it, and predicts its result.
	task automatic send_item(input logic req, input logic typed, input logic [31:0] want);
		logic [31:0] w;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, req};
		do @(posedge clk); while (!s_tready);
		if (req) begin
			w = mt_next_word();
			pending_words = {pending_words, (typed ? want : w)};
		end
	endtask

	// The seed is only written once every word has come out and the block has settled.
	task automatic write_seed(input logic [31:0] value);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		seed_value_we    <= 1'b1;
		seed_value_wdata <= value;
		@(negedge clk);
		seed_value_we <= 1'b0;
		tbl_seed = value;
		tbl_pos  = POS_SEED_DUE;
		seeds_used++;
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		logic [31:0] exp_word;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				note_fail($sformatf("word %08h with no request pending", m_tdata));
			end else begin
				exp_word = pending_words.pop_front();
				words_checked++;
				if (m_tdata !== exp_word)
					note_fail($sformatf("random_word expected %08h got %08h",
						exp_word, m_tdata));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || seed_value_we)
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("mt19937_generator verification failed");
			$finish;
		end
	end

	initial begin
		int          counts [4];
		int          tx_pct [4];
		int          rx_pct [4];
		logic [31:0] seeds  [4];
		int          sent;
		logic        req;

		counts = '{250, 35, 35, 35};
		tx_pct = '{0, 67, 0, 14};
		rx_pct = '{0, 0, 67, 14};
		seeds  = '{$urandom, 32'h0000_0001, $urandom, 32'hffff_fffe};
		seeds_used    = 0;
		twist_count   = 0;
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		tbl_seed      = BOOT_SEED;
		tbl_pos       = POS_SEED_DUE;
		for (int i = 0; i < TBL_LEN; i++)
			tbl[i] = 32'h0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < PLAN_ROWS; r++) begin
			case (plan[r].kind)
				ROW_SEED: write_seed(plan[r].arg);
				ROW_IDLE: send_item(1'b0, 1'b0, 32'h0);
				default:  send_item(1'b1, plan[r].typed, plan[r].want);
			endcase
		end

		// Each phase starts from a fresh seed and mixes idle transactions in among requests.
		for (int ph = 0; ph < 4; ph++) begin
			write_seed(seeds[ph]);
			tx_idle_pct = tx_pct[ph];
			rx_idle_pct = rx_pct[ph];
			sent = 0;
			while (sent < counts[ph]) begin
				req = ($urandom_range(99) >= 10);
				send_item(req, 1'b0, 32'h0);
				if (req)
					sent++;
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Checked %0d words under %0d seed writes, %0d table twists predicted,",
			words_checked, seeds_used, twist_count);
		$display("with idle gaps and output stalls mixed in across the phases.");
		if (fail_count == 0 && pending_words.size() == 0) begin
			$display("mt19937_generator verification clean");
		end else begin
			$display("%0d mismatches, %0d words never arrived", fail_count,
				pending_words.size());
			$display("mt19937_generator verification failed");
		end
		$finish;
	end

endmodule
